// ===== rtl/pfn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_pkg: shared constants for the polygon face normal core
// Fixed widths of the unit-vector datapath and the register reset value.
// ----------------------------------------------------------------------------
package pfn_pkg;

  // fraction bits of the unit edges
  localparam int UNIT_FRAC = 30;
  // signed width that holds edges and the cross product of unit edges
  localparam int VEC_W = 2 * UNIT_FRAC + 3;
  // signed width of a unit-vector component
  localparam int UQ_W = UNIT_FRAC + 2;
  // block scaling window: largest magnitude in [2^(NORM_HI-1), 2^NORM_HI)
  localparam int NORM_HI = 30;
  // divider and square root widths
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 32;
  localparam int SQ_IN_W = 64;
  localparam int SQ_OUT_W = 32;
  // collinearity limit register
  localparam int COS_W = 16;
  localparam int COS_SHIFT = 44;
  localparam logic [COS_W-1:0] COS_LIMIT_RESET = 16'd65497;

endpackage

// ===== rtl/pfn_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_if: channel interfaces of the polygon face normal core
// Vertex channel and normal channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface pfn_vtx_if #(parameter int COORD_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic                          last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, last_vertex, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, last_vertex, output ready);
endinterface

interface pfn_nrm_if #(parameter int NORMAL_FRAC_BITS = 14) ();
  logic                               valid;
  logic                               ready;
  logic signed [NORMAL_FRAC_BITS+1:0] normal_x;
  logic signed [NORMAL_FRAC_BITS+1:0] normal_y;
  logic signed [NORMAL_FRAC_BITS+1:0] normal_z;
  logic                               used_fallback;

  modport source (output valid, normal_x, normal_y, normal_z, used_fallback, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, used_fallback, output ready);
endinterface

// ===== rtl/pfn_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_sqrt: iterative floor square root
// Two radicand bits per cycle, one root bit per cycle.
// ----------------------------------------------------------------------------
module pfn_sqrt
  import pfn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SQ_IN_W-1:0]  radicand,
  output logic                done,
  output logic [SQ_OUT_W-1:0] root
);

  localparam int CNT_W = $clog2(SQ_OUT_W);
  localparam int REM_W = SQ_OUT_W + 2;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [SQ_IN_W-1:0] n;
  logic [REM_W-1:0]   rem;
  logic [REM_W+1:0]   r2;
  logic [REM_W+1:0]   trial;

  // trial subtraction for the next root bit
  always_comb begin
    r2    = {rem, n[SQ_IN_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        n    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        n <= n << 2;
        if (r2 >= trial) begin
          rem  <= REM_W'(r2 - trial);
          root <= {root[SQ_OUT_W-2:0], 1'b1};
        end else begin
          rem  <= r2[REM_W-1:0];
          root <= {root[SQ_OUT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SQ_OUT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/pfn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_div: iterative unsigned restoring divider
// One quotient bit per cycle; the quotient must fit in DIV_D_W bits.
// ----------------------------------------------------------------------------
module pfn_div
  import pfn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_D_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_D_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] d;
  logic [DIV_D_W:0]   t;
  logic               ge;

  // partial remainder with the next dividend bit
  always_comb begin
    t  = {rem, quotient[DIV_D_W-1]};
    ge = (t >= {1'b0, d});
  end

  // low dividend bits shift out of quotient as quotient bits shift in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= dividend[DIV_N_W-1 -: DIV_D_W];
        quotient <= dividend[DIV_D_W-1:0];
        d        <= divisor;
      end else if (busy) begin
        rem      <= ge ? DIV_D_W'(t - {1'b0, d}) : t[DIV_D_W-1:0];
        quotient <= {quotient[DIV_D_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_D_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/pfn_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_unit: vector normaliser
// Block scales the magnitudes, takes the length by square root and divides
// each component by it, truncated or rounded to nearest.
// ----------------------------------------------------------------------------
module pfn_unit
  import pfn_pkg::*;
#(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    rnd,
  input  logic signed [VEC_W-1:0] vec_in [3],
  output logic                    done,
  output logic signed [UQ_W-1:0]  vec_out [3]
);

  localparam logic [2:0] U_IDLE      = 3'd0;
  localparam logic [2:0] U_SHIFT     = 3'd1;
  localparam logic [2:0] U_SQ        = 3'd2;
  localparam logic [2:0] U_SQRT      = 3'd3;
  localparam logic [2:0] U_SQRT_WAIT = 3'd4;
  localparam logic [2:0] U_DIV       = 3'd5;
  localparam logic [2:0] U_DIV_WAIT  = 3'd6;

  logic [2:0]               state;
  logic                     neg [3];
  logic [VEC_W-1:0]         m [3];
  logic                     rnd_q;
  logic [SQ_IN_W-1:0]       sq;
  logic [2*NORM_HI-1:0]     prod;
  logic [1:0]               idx;
  logic [SQ_OUT_W-1:0]      len;
  logic [VEC_W-1:0]         any_m;
  logic                     in_zero;
  logic [NORM_HI-1:0]       m_sel;
  logic [DIV_N_W-1:0]       dividend;
  logic [DIV_D_W-1:0]       divisor;
  logic                     sqrt_done;
  logic [SQ_OUT_W-1:0]      root;
  logic                     div_done;
  logic [DIV_D_W-1:0]       quotient;

  // scaling window test and divider operands
  always_comb begin
    any_m   = m[0] | m[1] | m[2];
    in_zero = (vec_in[0] == '0) && (vec_in[1] == '0) && (vec_in[2] == '0);
    m_sel   = (idx == 2'd3) ? '0 : m[idx][NORM_HI-1:0];
    if (rnd_q) begin
      dividend = (DIV_N_W'(m_sel) << (NORMAL_FRAC_BITS + 1)) + DIV_N_W'(len);
      divisor  = {len[DIV_D_W-2:0], 1'b0};
    end else begin
      dividend = DIV_N_W'(m_sel) << UNIT_FRAC;
      divisor  = len;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            rnd_q <= rnd;
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vec_in[i][VEC_W-1];
              m[i]   <= vec_in[i][VEC_W-1] ? VEC_W'(-vec_in[i]) : VEC_W'(vec_in[i]);
            end
            if (in_zero) begin
              for (int i = 0; i < 3; i++) vec_out[i] <= '0;
              done <= 1'b1;
            end else begin
              state <= U_SHIFT;
            end
          end
        end
        U_SHIFT: begin
          if (|any_m[VEC_W-1:NORM_HI]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (!any_m[NORM_HI-1]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            idx   <= '0;
            sq    <= '0;
            prod  <= '0;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          // product registered, then added into the sum from that register
          prod <= m_sel * m_sel;
          sq   <= sq + SQ_IN_W'(prod);
          idx  <= idx + 1'b1;
          if (idx == 2'd3) state <= U_SQRT;
        end
        U_SQRT: begin
          state <= U_SQRT_WAIT;
        end
        U_SQRT_WAIT: begin
          if (sqrt_done) begin
            len   <= root;
            idx   <= '0;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          state <= U_DIV_WAIT;
        end
        U_DIV_WAIT: begin
          if (div_done) begin
            vec_out[idx] <= neg[idx] ? -$signed(UQ_W'(quotient)) : $signed(UQ_W'(quotient));
            if (idx == 2'd2) begin
              done  <= 1'b1;
              state <= U_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= U_DIV;
            end
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  pfn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == U_SQRT),
    .radicand (sq),
    .done     (sqrt_done),
    .root     (root)
  );

  pfn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == U_DIV),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

// ===== rtl/polygon_face_normal_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_face_normal_core: unit face normal of a polygon from its vertices
// A vertex that does not complete three distinct points passes through the
// compare and finish states before the next ready. A vertex that completes
// three points normalises both edges, forms dot and cross products on one
// shared 32x32 multiplier and, when the points are not collinear, normalises
// the cross product. The bit-serial block scaling shift, the one-bit-per-cycle
// square root and the one-bit-per-cycle divider all sit in one shared
// normaliser. The result of the last vertex sits in an output register; the
// next vertex may be accepted while it waits.
// ----------------------------------------------------------------------------
module polygon_face_normal_core
  import pfn_pkg::*;
#(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  pfn_vtx_if.sink          vtx,
  pfn_nrm_if.source        nrm,
  input  logic             cfg_wr_en,
  input  logic [COS_W-1:0] cfg_wr_data
);

  localparam int NW = NORMAL_FRAC_BITS + 2;
  localparam int PW = 2 * UQ_W;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CMP      = 4'd1;
  localparam logic [3:0] ST_UU_GO    = 4'd2;
  localparam logic [3:0] ST_UU_WAIT  = 4'd3;
  localparam logic [3:0] ST_VU_GO    = 4'd4;
  localparam logic [3:0] ST_VU_WAIT  = 4'd5;
  localparam logic [3:0] ST_MUL      = 4'd6;
  localparam logic [3:0] ST_TEST     = 4'd7;
  localparam logic [3:0] ST_NRM_WAIT = 4'd8;
  localparam logic [3:0] ST_FIN      = 4'd9;

  logic [3:0]                    state;
  logic [COS_W-1:0]              cos_limit;
  logic signed [COORD_WIDTH-1:0] kept_x [3];
  logic signed [COORD_WIDTH-1:0] kept_y [3];
  logic signed [COORD_WIDTH-1:0] kept_z [3];
  logic [1:0]                    kept_count;
  logic                          found;
  logic signed [NW-1:0]          held [3];
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;
  logic                          in_last;
  logic signed [UQ_W-1:0]        uu [3];
  logic signed [UQ_W-1:0]        vu [3];
  logic signed [VEC_W-1:0]       dot;
  logic signed [VEC_W-1:0]       cr [3];
  logic [3:0]                    mk;
  logic                          mphase;
  logic signed [PW-1:0]          prod;
  logic signed [UQ_W-1:0]        mul_a;
  logic signed [UQ_W-1:0]        mul_b;
  logic                          fresh;
  logic signed [VEC_W-1:0]       edge_u [3];
  logic signed [VEC_W-1:0]       edge_v [3];
  logic signed [VEC_W-1:0]       unit_in [3];
  logic                          unit_start;
  logic                          unit_done;
  logic signed [UQ_W-1:0]        unit_out [3];
  logic [VEC_W-1:0]              dot_mag;
  logic                          reject;
  logic                          out_valid;

  assign vtx.ready = (state == ST_IDLE);
  assign nrm.valid = out_valid;

  // duplicate check against kept points and edge vectors
  always_comb begin
    fresh = 1'b1;
    for (int j = 0; j < 3; j++) begin
      if ((2'(j) < kept_count) && (kept_x[j] == in_x) && (kept_y[j] == in_y) &&
          (kept_z[j] == in_z)) fresh = 1'b0;
    end
    edge_u[0] = VEC_W'(kept_x[0]) - VEC_W'(kept_x[1]);
    edge_u[1] = VEC_W'(kept_y[0]) - VEC_W'(kept_y[1]);
    edge_u[2] = VEC_W'(kept_z[0]) - VEC_W'(kept_z[1]);
    edge_v[0] = VEC_W'(kept_x[1]) - VEC_W'(kept_x[2]);
    edge_v[1] = VEC_W'(kept_y[1]) - VEC_W'(kept_y[2]);
    edge_v[2] = VEC_W'(kept_z[1]) - VEC_W'(kept_z[2]);
  end

  // collinearity and degenerate cross product test
  always_comb begin
    dot_mag = dot[VEC_W-1] ? VEC_W'(-dot) : VEC_W'(dot);
    reject  = (dot_mag > (VEC_W'(cos_limit) << COS_SHIFT)) ||
              ((cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0));
  end

  // normaliser operand select
  always_comb begin
    unit_start = (state == ST_UU_GO) || (state == ST_VU_GO) ||
                 ((state == ST_TEST) && !reject);
    for (int i = 0; i < 3; i++) begin
      case (state)
        ST_UU_GO: unit_in[i] = edge_u[i];
        ST_VU_GO: unit_in[i] = edge_v[i];
        default:  unit_in[i] = cr[i];
      endcase
    end
  end

  // multiplier operand schedule: dot product, then cross product terms
  always_comb begin
    case (mk)
      4'd0:    begin mul_a = uu[0]; mul_b = vu[0]; end
      4'd1:    begin mul_a = uu[1]; mul_b = vu[1]; end
      4'd2:    begin mul_a = uu[2]; mul_b = vu[2]; end
      4'd3:    begin mul_a = uu[1]; mul_b = vu[2]; end
      4'd4:    begin mul_a = uu[2]; mul_b = vu[1]; end
      4'd5:    begin mul_a = uu[2]; mul_b = vu[0]; end
      4'd6:    begin mul_a = uu[0]; mul_b = vu[2]; end
      4'd7:    begin mul_a = uu[0]; mul_b = vu[1]; end
      default: begin mul_a = uu[1]; mul_b = vu[0]; end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_limit <= COS_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      cos_limit <= cfg_wr_data;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      kept_count <= '0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // a taken result clears unless a new one is loaded in the same cycle
      if (out_valid && nrm.ready && !((state == ST_FIN) && in_last)) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (vtx.valid) begin
            in_x    <= vtx.pos_x;
            in_y    <= vtx.pos_y;
            in_z    <= vtx.pos_z;
            in_last <= vtx.last_vertex;
            state   <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (!found && fresh && (kept_count != 2'd3)) begin
            kept_x[kept_count] <= in_x;
            kept_y[kept_count] <= in_y;
            kept_z[kept_count] <= in_z;
            kept_count         <= kept_count + 1'b1;
            state              <= (kept_count == 2'd2) ? ST_UU_GO : ST_FIN;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_UU_GO: state <= ST_UU_WAIT;
        ST_UU_WAIT: begin
          if (unit_done) begin
            uu    <= unit_out;
            state <= ST_VU_GO;
          end
        end
        ST_VU_GO: state <= ST_VU_WAIT;
        ST_VU_WAIT: begin
          if (unit_done) begin
            vu     <= unit_out;
            mk     <= '0;
            mphase <= 1'b0;
            dot    <= '0;
            for (int i = 0; i < 3; i++) cr[i] <= '0;
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          mphase <= ~mphase;
          if (!mphase) begin
            prod <= mul_a * mul_b;
          end else begin
            case (mk)
              4'd0, 4'd1, 4'd2: dot <= dot + VEC_W'(prod);
              4'd3:    cr[0] <= cr[0] + VEC_W'(prod);
              4'd4:    cr[0] <= cr[0] - VEC_W'(prod);
              4'd5:    cr[1] <= cr[1] + VEC_W'(prod);
              4'd6:    cr[1] <= cr[1] - VEC_W'(prod);
              4'd7:    cr[2] <= cr[2] + VEC_W'(prod);
              default: cr[2] <= cr[2] - VEC_W'(prod);
            endcase
            if (mk == 4'd8) state <= ST_TEST;
            else mk <= mk + 1'b1;
          end
        end
        ST_TEST: begin
          if (reject) begin
            kept_count <= 2'd2;
            state      <= ST_FIN;
          end else begin
            state <= ST_NRM_WAIT;
          end
        end
        ST_NRM_WAIT: begin
          if (unit_done) begin
            for (int i = 0; i < 3; i++) held[i] <= NW'(unit_out[i]);
            found <= 1'b1;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!in_last) begin
            state <= ST_IDLE;
          end else if (!out_valid || nrm.ready) begin
            // emit the held normal or the fallback, then start a new polygon
            out_valid         <= 1'b1;
            nrm.used_fallback <= !found;
            if (found) begin
              nrm.normal_x <= held[0];
              nrm.normal_y <= held[1];
              nrm.normal_z <= held[2];
            end else begin
              nrm.normal_x <= '0;
              nrm.normal_y <= '0;
              nrm.normal_z <= NW'(1) << NORMAL_FRAC_BITS;
            end
            kept_count <= '0;
            found      <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  pfn_unit #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_unit (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .rnd     (state == ST_TEST),
    .vec_in  (unit_in),
    .done    (unit_done),
    .vec_out (unit_out)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for polygon_face_normal_core
// Streams polygons into the vertex channel with random gaps, stalls the
// normal channel at random and compares every normal with a bit-exact
// fixed-point predictor. Several collinearity limits are exercised.
// ----------------------------------------------------------------------------
module tb;
  import pfn_pkg::*;

  localparam int CW      = 32;
  localparam int NF      = 14;
  localparam int NW      = NF + 2;
  localparam int WD_MAX  = 8000;
  localparam int SETTLE  = 700;
  localparam int N_RAND  = 1700;

  typedef longint vec3_t [3];

  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
    logic                 fallback;
  } normal_t;

  // --------------------------------------------------------------------------
  // normal predictor and store of expected normals
  // --------------------------------------------------------------------------
  class normal_scoreboard;
    logic [COS_W-1:0] cos_limit;
    longint           pts_x [3];
    longint           pts_y [3];
    longint           pts_z [3];
    int               n_pts;
    bit               found;
    vec3_t            held;
    normal_t          pending_q [$];
    int               errors;

    function new();
      cos_limit = COS_LIMIT_RESET;
      n_pts     = 0;
      found     = 0;
      errors    = 0;
      held      = '{0, 0, 0};
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic longint unsigned magn(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // block-scaled normalisation to frac fraction bits
    function automatic void to_unit(input vec3_t vi, output vec3_t vo, input int frac,
                                    input bit rnd);
      longint unsigned m [3];
      longint unsigned mx, sq, len, q;
      mx = 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = magn(vi[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        vo = '{0, 0, 0};
        return;
      end
      while (mx >= (64'd1 << 30)) begin
        mx = mx >> 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx = mx << 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      for (int i = 0; i < 3; i++) sq += m[i] * m[i];
      len = floor_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        if (rnd) q = ((m[i] << (frac + 1)) + len) / (2 * len);
        else     q = (m[i] << frac) / len;
        vo[i] = (vi[i] < 0) ? -longint'(q) : longint'(q);
      end
    endfunction

    function automatic void try_plane();
      vec3_t u, v, uu, vu, c;
      longint dot;
      longint unsigned lim;
      lim  = longint'(cos_limit) << COS_SHIFT;
      u[0] = pts_x[0] - pts_x[1]; u[1] = pts_y[0] - pts_y[1]; u[2] = pts_z[0] - pts_z[1];
      v[0] = pts_x[1] - pts_x[2]; v[1] = pts_y[1] - pts_y[2]; v[2] = pts_z[1] - pts_z[2];
      to_unit(u, uu, UNIT_FRAC, 1'b0);
      to_unit(v, vu, UNIT_FRAC, 1'b0);
      dot = uu[0] * vu[0] + uu[1] * vu[1] + uu[2] * vu[2];
      if (magn(dot) > lim) begin
        n_pts = 2;
        return;
      end
      c[0] = uu[1] * vu[2] - uu[2] * vu[1];
      c[1] = uu[2] * vu[0] - uu[0] * vu[2];
      c[2] = uu[0] * vu[1] - uu[1] * vu[0];
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
        n_pts = 2;
        return;
      end
      to_unit(c, held, NF, 1'b1);
      found = 1;
    endfunction

    // accepted vertex transaction
    function automatic void note_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                        logic signed [CW-1:0] z, logic last);
      bit      fresh;
      normal_t e;
      if (!found) begin
        fresh = 1;
        for (int j = 0; j < n_pts; j++)
          if (pts_x[j] == x && pts_y[j] == y && pts_z[j] == z) fresh = 0;
        if (fresh && n_pts < 3) begin
          pts_x[n_pts] = x;
          pts_y[n_pts] = y;
          pts_z[n_pts] = z;
          n_pts++;
          if (n_pts == 3) try_plane();
        end
      end
      if (last) begin
        if (found) begin
          e.nx = held[0][NW-1:0];
          e.ny = held[1][NW-1:0];
          e.nz = held[2][NW-1:0];
          e.fallback = 1'b0;
        end else begin
          e.nx = '0;
          e.ny = '0;
          e.nz = NW'(1 << NF);
          e.fallback = 1'b1;
        end
        pending_q.push_back(e);
        n_pts = 0;
        found = 0;
        held  = '{0, 0, 0};
      end
    endfunction

    // accepted normal transaction
    function automatic void check_normal(normal_t got);
      normal_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected normal %0d %0d %0d fb %0d", $time,
                 got.nx, got.ny, got.nz, got.fallback);
        return;
      end
      e = pending_q.pop_front();
      if (got.nx !== e.nx) begin
        errors++;
        $display("%0t: normal_x expected %0d actual %0d", $time, e.nx, got.nx);
      end
      if (got.ny !== e.ny) begin
        errors++;
        $display("%0t: normal_y expected %0d actual %0d", $time, e.ny, got.ny);
      end
      if (got.nz !== e.nz) begin
        errors++;
        $display("%0t: normal_z expected %0d actual %0d", $time, e.nz, got.nz);
      end
      if (got.fallback !== e.fallback) begin
        errors++;
        $display("%0t: used_fallback expected %0d actual %0d", $time,
                 e.fallback, got.fallback);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [COS_W-1:0] cfg_wr_data;
  bit               no_idle;
  int               quiet_cycles;

  pfn_vtx_if #(.COORD_WIDTH(CW))      vtx_ch ();
  pfn_nrm_if #(.NORMAL_FRAC_BITS(NF)) nrm_ch ();

  normal_scoreboard sb = new();

  polygon_face_normal_core #(
    .COORD_WIDTH     (CW),
    .NORMAL_FRAC_BITS(NF)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .vtx        (vtx_ch.sink),
    .nrm        (nrm_ch.source),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // monitors on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (vtx_ch.valid && vtx_ch.ready)
        sb.note_vertex(vtx_ch.pos_x, vtx_ch.pos_y, vtx_ch.pos_z, vtx_ch.last_vertex);
      if (nrm_ch.valid && nrm_ch.ready)
        sb.check_normal('{nrm_ch.normal_x, nrm_ch.normal_y, nrm_ch.normal_z,
                          nrm_ch.used_fallback});
    end
  end

  // watchdog on transaction-free cycles
  always @(posedge clk) begin
    if (rst || (vtx_ch.valid && vtx_ch.ready) || (nrm_ch.valid && nrm_ch.ready) ||
        cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stalls
  initial begin
    nrm_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int stall;
      stall = pick_gap();
      if (stall > 0) begin
        nrm_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      nrm_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // one vertex transaction, returns after acceptance edge
  task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [CW-1:0] z, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      vtx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx_ch.valid       <= 1'b1;
    vtx_ch.pos_x       <= x;
    vtx_ch.pos_y       <= y;
    vtx_ch.pos_z       <= z;
    vtx_ch.last_vertex <= last;
    do @(posedge clk); while (!(vtx_ch.valid && vtx_ch.ready));
  endtask

  // wait for every normal, then let any background work finish
  task automatic drain();
    vtx_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [COS_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    sb.cos_limit = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0:       return $signed($urandom_range(0, 16)) - 8;
      1:       return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      default: return $urandom;
    endcase
  endfunction

  // random polygon: mostly well-formed, with duplicates and collinear points
  task automatic send_polygon(ref int items);
    int mode, nv, r;
    logic signed [CW-1:0] px [3];
    logic signed [CW-1:0] py [3];
    logic signed [CW-1:0] pz [3];
    logic signed [CW-1:0] x, y, z;
    mode = ($urandom_range(0, 9) < 2) ? 2 : $urandom_range(0, 1);
    nv   = $urandom_range(1, 7);
    for (int i = 0; i < nv; i++) begin
      r = $urandom_range(0, 99);
      x = rand_coord(mode);
      y = rand_coord(mode);
      z = rand_coord(mode);
      if (i > 0 && r < 20) begin
        x = px[(i - 1) % 3]; y = py[(i - 1) % 3]; z = pz[(i - 1) % 3];
      end else if (i >= 2 && r < 35 && mode != 2) begin
        // extend the edge from the first to the second point to give a collinear point
        x = px[1] + (px[1] - px[0]) * $urandom_range(1, 3);
        y = py[1] + (py[1] - py[0]) * $urandom_range(1, 3);
        z = pz[1] + (pz[1] - pz[0]) * $urandom_range(1, 3);
      end
      if (i < 3) begin
        px[i] = x; py[i] = y; pz[i] = z;
      end
      send_vertex(x, y, z, i == nv - 1);
      items++;
    end
  endtask

  localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] CMIN = 32'sh80000000;
  localparam logic signed [CW-1:0] ONE  = 32'sh00010000;

  initial begin
    int items;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    no_idle            = 1'b0;
    quiet_cycles       = 0;
    vtx_ch.valid       = 1'b0;
    vtx_ch.pos_x       = '0;
    vtx_ch.pos_y       = '0;
    vtx_ch.pos_z       = '0;
    vtx_ch.last_vertex = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single vertex falls back
    send_vertex(0, 0, 0, 1);
    // right-angle triangle in the xy plane
    send_vertex(0, 0, 0, 0);
    send_vertex(ONE, 0, 0, 0);
    send_vertex(ONE, ONE, 0, 1);
    // duplicates dropped, then a normal, then vertices ignored after it
    send_vertex(ONE, 0, 0, 0);
    send_vertex(ONE, 0, 0, 0);
    send_vertex(0, ONE, 0, 0);
    send_vertex(0, 0, ONE, 0);
    send_vertex(CMAX, CMIN, CMAX, 0);
    send_vertex(5, 6, 7, 1);
    // collinear third point replaced by a usable one
    send_vertex(0, 0, 0, 0);
    send_vertex(ONE, ONE, ONE, 0);
    send_vertex(2 * ONE, 2 * ONE, 2 * ONE, 0);
    send_vertex(0, ONE, -ONE, 1);
    // extreme coordinates
    send_vertex(CMIN, CMIN, CMIN, 0);
    send_vertex(CMAX, CMAX, CMAX, 0);
    send_vertex(CMIN, CMAX, 0, 1);
    // two points only
    send_vertex(-1, -1, -1, 0);
    send_vertex(1, 1, 1, 1);
    drain();

    // limit extremes: zero rejects anything not exactly square
    write_limit(16'd0);
    send_vertex(0, 0, 0, 0);
    send_vertex(ONE, 0, 0, 0);
    send_vertex(ONE, ONE, 0, 1);
    send_vertex(0, 0, 0, 0);
    send_vertex(ONE, 0, 0, 0);
    send_vertex(2 * ONE, ONE, 0, 1);
    drain();
    write_limit(16'hffff);

    items = 0;
    for (int phase = 0; phase < 6; phase++) begin
      no_idle = (phase == 3);
      while (items < (phase + 1) * N_RAND / 6) send_polygon(items);
      drain();
      case (phase)
        0:       write_limit(COS_LIMIT_RESET);
        1:       write_limit(16'd0);
        2:       write_limit(16'($urandom));
        3:       write_limit(16'hffff);
        default: write_limit(16'($urandom_range(60000, 65535)));
      endcase
    end
    drain();

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
